@@ rtl/berie_pkg.sv @@
`timescale 1ns / 1ps

package berie_pkg;

    localparam int TAG_WIDTH = 32;
    localparam int LEN_BYTES = 4;
    localparam int INT_BYTES = 8;

    localparam int LEN_W = 8 * LEN_BYTES;
    localparam int LB_W  = $clog2(LEN_BYTES + 1);
    localparam int CB_W  = $clog2(INT_BYTES + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 144;

    localparam logic [7:0] TAG_MULTI_MASK = 8'h1f;
    localparam logic [7:0] LEN_INDEFINITE = 8'h80;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_TAG = 2'd0,
        CFG_SIGNED_MODE  = 2'd1,
        CFG_FILLER_TAG   = 2'd2
    } cfg_idx_e;

    typedef enum logic [2:0] {
        PH_TAG_FIRST = 3'd0,
        PH_TAG_MORE  = 3'd1,
        PH_LEN_FIRST = 3'd2,
        PH_LEN_MORE  = 3'd3,
        PH_CONTENT   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_WRONG_TAG  = 3'd1,
        ERR_INDEFINITE = 3'd2,
        ERR_LEN_OVF    = 3'd3,
        ERR_INT_BIG    = 3'd4
    } err_t;

    typedef struct packed {
        logic [31:0] expected_tag;
        logic        signed_mode;
        logic [7:0]  filler_tag;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  error_code;
        logic [7:0]  element_bytes;
        logic [63:0] int_value;
        logic [31:0] content_length;
        logic [31:0] tag_value;
    } result_t;

endpackage

@@ rtl/berie_in_reg.sv @@
`timescale 1ns / 1ps

module berie_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_byte
);
    import berie_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_data;
        end
    end

endmodule

@@ rtl/berie_core.sv @@
`timescale 1ns / 1ps

module berie_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [berie_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [berie_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               step,
    input  logic [7:0]                         in_byte,
    output logic                               res_valid,
    output berie_pkg::result_t                 res
);
    import berie_pkg::*;

    cfg_t                 cfg_reg;
    phase_t               phase_reg,   phase_next;
    logic [TAG_WIDTH-1:0] tag_reg,     tag_next;
    logic [LEN_W-1:0]     len_reg,     len_next;
    logic [LB_W-1:0]      lb_left_reg, lb_left_next;
    logic [63:0]          val_reg,     val_next;
    logic [CB_W-1:0]      cb_left_reg, cb_left_next;
    logic [7:0]           bc_reg,      bc_next;

    logic [LEN_W-1:0]     len_base;
    logic [63:0]          val_base;
    logic [7:0]           bc_base;
    logic [LEN_W-1:0]     len_cand;
    logic [LB_W-1:0]      lb_dec;
    logic [CB_W-1:0]      cb_dec;
    logic                 tag_ok_first;
    logic                 tag_ok_more;
    logic [TAG_WIDTH-1:0] tag_first;
    logic [TAG_WIDTH-1:0] tag_more;
    logic [LEN_W-1:0]     res_len;
    logic [63:0]          res_val;
    err_t                 res_err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_tag <= 32'd2;
            cfg_reg.signed_mode  <= 1'b1;
            cfg_reg.filler_tag   <= 8'hff;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_EXPECTED_TAG: cfg_reg.expected_tag <= cfg_data;
                CFG_SIGNED_MODE:  cfg_reg.signed_mode  <= cfg_data[0];
                CFG_FILLER_TAG:   cfg_reg.filler_tag   <= cfg_data[7:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        len_base  = (phase_reg == PH_TAG_FIRST) ? '0 : len_reg;
        val_base  = (phase_reg == PH_TAG_FIRST) ? '0 : val_reg;
        bc_base   = (phase_reg == PH_TAG_FIRST) ? '0 : bc_reg;
        tag_first = TAG_WIDTH'(in_byte);
        tag_more  = TAG_WIDTH'({tag_reg, in_byte});
        tag_ok_first = (64'(tag_first) == 64'(cfg_reg.expected_tag));
        tag_ok_more  = (64'(tag_more) == 64'(cfg_reg.expected_tag));
        lb_dec = (lb_left_reg != '0) ? lb_left_reg - LB_W'(1) : lb_left_reg;
        cb_dec = (cb_left_reg != '0) ? cb_left_reg - CB_W'(1) : cb_left_reg;
        len_cand = '0;

        phase_next   = phase_reg;
        tag_next     = tag_reg;
        len_next     = len_base;
        lb_left_next = lb_left_reg;
        val_next     = val_base;
        cb_left_next = cb_left_reg;
        bc_next      = (bc_base < 8'd255) ? bc_base + 8'd1 : bc_base;

        res_valid = 1'b0;
        res_len   = '0;
        res_val   = '0;
        res_err   = ERR_NONE;

        unique case (phase_reg)
            PH_TAG_FIRST:
            begin
                tag_next = tag_first;
                if (((in_byte & TAG_MULTI_MASK) == TAG_MULTI_MASK)
                    && (in_byte != cfg_reg.filler_tag))
                begin
                    phase_next = PH_TAG_MORE;
                end
                else if (!tag_ok_first)
                begin
                    res_valid = 1'b1;
                    res_err   = ERR_WRONG_TAG;
                end
                else
                begin
                    phase_next = PH_LEN_FIRST;
                end
            end
            PH_TAG_MORE:
            begin
                tag_next = tag_more;
                if (!in_byte[7])
                begin
                    if (!tag_ok_more)
                    begin
                        res_valid = 1'b1;
                        res_err   = ERR_WRONG_TAG;
                    end
                    else
                    begin
                        phase_next = PH_LEN_FIRST;
                    end
                end
            end
            PH_LEN_FIRST:
            begin
                if (!in_byte[7])
                begin
                    len_next = LEN_W'(in_byte);
                    len_cand = LEN_W'(in_byte);
                    phase_next = PH_LEN_MORE;
                end
                else if (in_byte == LEN_INDEFINITE)
                begin
                    res_valid = 1'b1;
                    res_err   = ERR_INDEFINITE;
                end
                else if (32'(in_byte[6:0]) > LEN_BYTES)
                begin
                    res_valid = 1'b1;
                    res_err   = ERR_LEN_OVF;
                end
                else
                begin
                    lb_left_next = LB_W'(in_byte[6:0]);
                    len_next     = '0;
                    phase_next   = PH_LEN_MORE;
                end
            end
            PH_LEN_MORE:
            begin
                len_next     = LEN_W'({len_reg, in_byte});
                len_cand     = LEN_W'({len_reg, in_byte});
                lb_left_next = lb_dec;
                if (lb_dec != '0)
                begin
                    phase_next = PH_LEN_MORE;
                end
            end
            PH_CONTENT:
            begin
                if (LEN_W'(cb_left_reg) == len_reg)
                begin
                    if (cfg_reg.signed_mode && in_byte[7])
                    begin
                        val_next = {{56{1'b1}}, in_byte};
                    end
                    else
                    begin
                        val_next = 64'(in_byte);
                    end
                end
                else
                begin
                    val_next = {val_reg[55:0], in_byte};
                end
                cb_left_next = cb_dec;
                if (cb_dec == '0)
                begin
                    res_valid = 1'b1;
                    res_len   = len_reg;
                    res_val   = val_next;
                end
            end
            default:
            begin
                phase_next = PH_TAG_FIRST;
            end
        endcase

        // length complete: short form, or last long-form byte
        if (((phase_reg == PH_LEN_FIRST) && !in_byte[7])
            || ((phase_reg == PH_LEN_MORE) && (lb_dec == '0)))
        begin
            if (len_cand > LEN_W'(INT_BYTES))
            begin
                res_valid = 1'b1;
                res_len   = len_cand;
                res_err   = ERR_INT_BIG;
            end
            else if (len_cand == '0)
            begin
                res_valid = 1'b1;
            end
            else
            begin
                cb_left_next = CB_W'(len_cand);
                val_next     = '0;
                phase_next   = PH_CONTENT;
            end
        end

        if (res_valid)
        begin
            phase_next = PH_TAG_FIRST;
        end

        res.tag_value      = 32'(tag_next);
        res.content_length = 32'(res_len);
        res.int_value      = res_val;
        res.element_bytes  = bc_next;
        res.error_code     = res_err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG_FIRST;
            tag_reg     <= '0;
            len_reg     <= '0;
            lb_left_reg <= '0;
            val_reg     <= '0;
            cb_left_reg <= '0;
            bc_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            lb_left_reg <= lb_left_next;
            val_reg     <= val_next;
            cb_left_reg <= cb_left_next;
            bc_reg      <= bc_next;
        end
    end

endmodule

@@ rtl/berie_out_reg.sv @@
`timescale 1ns / 1ps

module berie_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  berie_pkg::result_t                  res,
    output logic                                can_load,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [berie_pkg::OUT_DATA_W-1:0]    out_data
);
    import berie_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = OUT_DATA_W'(res_reg);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

@@ rtl/ber_integer_element_decoder.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Width  Contents
// s_axis    in   8      in_byte
// m_axis    out  144    tag_value, content_length, int_value, element_bytes, error_code
// cfg       in   2+32   register index, write data
//
// One byte per cycle sustained unless a result stalls; each result is registered at the output.
// The per-byte decode step is one short compare/shift stage between input and result registers.
// Reset clears all control state and loads register defaults.
// A stalled result holds the decoder; the input register still takes one request.

module ber_integer_element_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] in_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] tag_value, [63:32] content_length, [127:64] int_value,
    // [135:128] element_bytes, [138:136] error_code, [143:139] zero
    output logic [berie_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [berie_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [berie_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import berie_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       can_load;
    logic       step;
    logic       res_valid;
    result_t    res;

    assign step = held_valid && can_load;

    berie_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .advance    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    berie_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .in_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    berie_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res       (res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import berie_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    ber_integer_element_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // register copies and decoder state
    logic [31:0] exp_tag_cfg = 32'd2;
    logic        signed_cfg  = 1'b1;
    logic [7:0]  filler_cfg  = 8'hff;

    phase_t      dec_phase        = PH_TAG_FIRST;
    logic [31:0] dec_tag          = '0;
    logic [31:0] dec_len          = '0;
    int          dec_len_left     = 0;
    logic [63:0] dec_val          = '0;
    int          dec_content_left = 0;
    logic [7:0]  dec_bytes        = '0;

    result_t     pending_elements[$];
    logic [7:0]  tag_seq[$];

    int  fail_count   = 0;
    int  bytes_sent   = 0;
    int  cycle_count  = 0;
    int  sink_wait    = 0;
    int  hold_reqs    = 0;
    int  hold_taken   = 0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;

    function automatic void post_element(input logic [31:0] len, input logic [63:0] val,
                                         input err_t err);
        result_t r;
        r.tag_value      = dec_tag;
        r.content_length = len;
        r.int_value      = val;
        r.element_bytes  = dec_bytes;
        r.error_code     = err;
        pending_elements.push_back(r);
        dec_phase = PH_TAG_FIRST;
    endfunction

    function automatic void finish_tag();
        if (dec_tag != exp_tag_cfg)
            post_element('0, '0, ERR_WRONG_TAG);
        else
            dec_phase = PH_LEN_FIRST;
    endfunction

    function automatic void finish_length();
        if (dec_len > INT_BYTES)
            post_element(dec_len, '0, ERR_INT_BIG);
        else if (dec_len == 0)
            post_element('0, '0, ERR_NONE);
        else
        begin
            dec_content_left = int'(dec_len);
            dec_val          = '0;
            dec_phase        = PH_CONTENT;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        if (dec_phase == PH_TAG_FIRST)
        begin
            dec_bytes = '0;
            dec_len   = '0;
            dec_val   = '0;
        end
        if (dec_bytes != 8'hff)
            dec_bytes++;
        case (dec_phase)
            PH_TAG_FIRST:
            begin
                dec_tag = {24'h0, b};
                if ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK && b != filler_cfg)
                    dec_phase = PH_TAG_MORE;
                else
                    finish_tag();
            end
            PH_TAG_MORE:
            begin
                dec_tag = {dec_tag[23:0], b};
                if (!b[7])
                    finish_tag();
            end
            PH_LEN_FIRST:
            begin
                if (!b[7])
                begin
                    dec_len = {24'h0, b};
                    finish_length();
                end
                else if (b == LEN_INDEFINITE)
                    post_element('0, '0, ERR_INDEFINITE);
                else if (b[6:0] > LEN_BYTES)
                    post_element('0, '0, ERR_LEN_OVF);
                else
                begin
                    dec_len_left = int'(b[6:0]);
                    dec_len      = '0;
                    dec_phase    = PH_LEN_MORE;
                end
            end
            PH_LEN_MORE:
            begin
                dec_len = {dec_len[23:0], b};
                if (dec_len_left > 0)
                    dec_len_left--;
                if (dec_len_left == 0)
                    finish_length();
            end
            PH_CONTENT:
            begin
                if (dec_content_left == dec_len)
                    dec_val = (signed_cfg && b[7]) ? {{56{1'b1}}, b} : {56'h0, b};
                else
                    dec_val = {dec_val[55:0], b};
                if (dec_content_left > 0)
                    dec_content_left--;
                if (dec_content_left == 0)
                    post_element(dec_len, dec_val, ERR_NONE);
            end
            default: dec_phase = PH_TAG_FIRST;
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_wait > 0)
        begin
            sink_wait <= sink_wait - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_taken != hold_reqs)
        begin
            hold_taken <= hold_reqs;
            sink_wait  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 7) == 0)
        begin
            sink_wait <= $urandom_range(0, 5);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_elements.size() == 0)
                note_failure($sformatf("unexpected result %h", got));
            else
            begin
                want = pending_elements.pop_front();
                if (got.tag_value !== want.tag_value)
                    note_failure($sformatf("tag_value exp %h got %h",
                                           want.tag_value, got.tag_value));
                if (got.content_length !== want.content_length)
                    note_failure($sformatf("content_length exp %h got %h",
                                           want.content_length, got.content_length));
                if (got.int_value !== want.int_value)
                    note_failure($sformatf("int_value exp %h got %h",
                                           want.int_value, got.int_value));
                if (got.element_bytes !== want.element_bytes)
                    note_failure($sformatf("element_bytes exp %0d got %0d",
                                           want.element_bytes, got.element_bytes));
                if (got.error_code !== want.error_code)
                    note_failure($sformatf("error_code exp %0d got %0d",
                                           want.error_code, got.error_code));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_elements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] tag, input logic sgn, input logic [7:0] fill);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_TAG;
        cfg_data  <= tag;
        @(posedge clk);
        cfg_index <= CFG_SIGNED_MODE;
        cfg_data  <= {31'h0, sgn};
        @(posedge clk);
        cfg_index <= CFG_FILLER_TAG;
        cfg_data  <= {24'h0, fill};
        @(posedge clk);
        cfg_we    <= 1'b0;
        exp_tag_cfg = tag;
        signed_cfg  = sgn;
        filler_cfg  = fill;
    endtask

    // build a tag encoding that the decoder accepts under this filler, and its value
    task automatic pick_tag(input logic [7:0] fill, output logic [31:0] value);
        logic [7:0] b;
        int         kind;
        kind = $urandom_range(0, 2);
        tag_seq.delete();
        if (kind == 0)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK && b != fill);
            tag_seq.push_back(b);
        end
        else if (kind == 1)
            tag_seq.push_back(fill);
        else
        begin
            do
                b = 8'($urandom_range(0, 255)) | TAG_MULTI_MASK;
            while (b == fill);
            tag_seq.push_back(b);
            repeat ($urandom_range(0, 5))
                tag_seq.push_back(8'h80 | 8'($urandom_range(0, 127)));
            tag_seq.push_back(8'($urandom_range(0, 127)));
        end
        value = '0;
        foreach (tag_seq[i])
            value = (i == 0) ? {24'h0, tag_seq[i]} : {value[23:0], tag_seq[i]};
    endtask

    task automatic send_tag();
        foreach (tag_seq[i])
            send_byte(tag_seq[i]);
    endtask

    task automatic send_length(input logic [31:0] len, input bit long_form);
        int need;
        int nlb;
        if (!long_form && len < 128)
            send_byte(len[7:0]);
        else
        begin
            need = (len > 32'hff_ffff) ? 4 : (len > 32'hffff) ? 3 : (len > 32'hff) ? 2 : 1;
            nlb  = $urandom_range(need, LEN_BYTES);
            send_byte(8'h80 | 8'(nlb));
            for (int i = nlb - 1; i >= 0; i--)
                send_byte(len[8*i +: 8]);
        end
    endtask

    task automatic send_content(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            if (i == 0)
                case ($urandom_range(0, 4))
                    0: b = 8'h00;
                    1: b = 8'h7f;
                    2: b = 8'h80;
                    3: b = 8'hff;
                    default: ;
                endcase
            send_byte(b);
        end
    endtask

    task automatic send_good_element();
        int len;
        len = $urandom_range(0, INT_BYTES);
        send_tag();
        send_length(len, $urandom_range(0, 2) == 0);
        send_content(len);
    endtask

    task automatic send_random_element();
        int          r;
        int          len;
        logic [31:0] big;
        r = $urandom_range(0, 99);
        if (r < 70)
            send_good_element();
        else if (r < 78)
        begin
            send_tag();
            case ($urandom_range(0, 3))
                0: send_byte(LEN_INDEFINITE);
                1: send_byte(8'h80 | 8'($urandom_range(LEN_BYTES + 1, 127)));
                2: send_length($urandom_range(INT_BYTES + 1, 127), 1'b0);
                default:
                begin
                    big = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff
                                                      : $urandom_range(INT_BYTES + 1, 32'hffff_ffff);
                    send_length(big, 1'b1);
                end
            endcase
        end
        else if (r < 88)
        begin
            len = $urandom_range(0, INT_BYTES);
            send_byte(8'($urandom_range(0, 255)));
            send_length(len, 1'b0);
            send_content(len);
        end
        else
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        logic [7:0] seq[$] = '{8'h02, 8'h01, 8'h05,
                               8'h02, 8'h01, 8'h80,
                               8'h02, 8'h00,
                               8'h03,
                               8'h02, 8'h80,
                               8'h02, 8'h85,
                               8'h02, 8'h09,
                               8'hff,
                               8'h1f, 8'h81, 8'h02,
                               8'h02, 8'h82, 8'h00, 8'h01, 8'h7f};
        foreach (seq[i])
            send_byte(seq[i]);
        drain();
    endtask

    // element longer than the byte counter can hold
    task automatic test_long_tag();
        set_config(32'h8080_8002, 1'b1, 8'hff);
        send_byte(8'h1f);
        repeat (256) send_byte(8'h80 | 8'($urandom_range(0, 127)));
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h02);
        send_byte(8'h01);
        send_byte(8'($urandom_range(0, 255)));
        drain();
    endtask

    task automatic test_random_phases();
        logic [31:0] tag;
        logic [7:0]  fill;
        int          quota;
        for (int p = 0; p < 6; p++)
        begin
            fill = (p == 0) ? 8'hff : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
            pick_tag(fill, tag);
            if (p == 2)
                tag = 32'hffff_ffff;
            if (p == 3)
            begin
                tag_seq.delete();
                tag_seq.push_back(8'h00);
                tag = '0;
            end
            set_config(tag, p[0], fill);
            src_idle_on  = (p != 4);
            sink_idle_on = (p != 4);
            quota = bytes_sent + 20;
            while (bytes_sent < quota)
            begin
                send_random_element();
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end
        drain();
    endtask

    // hold the result side while requests keep coming
    task automatic test_output_stall();
        logic [31:0] tag;
        int          quota;
        pick_tag(8'hff, tag);
        set_config(tag, 1'b1, 8'hff);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_reqs++;
        quota = bytes_sent + 60;
        while (bytes_sent < quota)
            send_good_element();
        drain();
    endtask

    task automatic test_streaming();
        int quota;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        quota = bytes_sent + 60;
        while (bytes_sent < quota)
            send_random_element();
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_long_tag();
        test_random_phases();
        test_output_stall();
        test_streaming();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/berie_pkg.sv
rtl/berie_in_reg.sv
rtl/berie_core.sv
rtl/berie_out_reg.sv
rtl/ber_integer_element_decoder.sv
bench/tb_top.sv
